FILE: rtl/bounded_sequence_list_engine_defines.svh
// Assertion macros for the bounded sequence list engine.
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/bsle_pkg.sv
package bsle_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 16;
    localparam int CMD_W     = 2;
    localparam int OUT_CNT_W = 7;

    localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -16'sd1;
    localparam logic signed [DATA_W-1:0] POP_NONE_VALUE  = 16'sd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_INSERT = 2'd3
    } bsle_cmd_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POP,
        OP_PUSH,
        OP_APPEND,
        OP_INSERT
    } bsle_op_t;

    typedef struct packed {
        logic     exec;
        bsle_op_t op;
        logic     empty_err;
        logic     full_err;
    } bsle_ctrl_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
    } bsle_stat_t;

endpackage

FILE: rtl/bsle_ctrl.sv
module bsle_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bsle_pkg::CMD_W-1:0]    s_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  bsle_pkg::bsle_stat_t          stat,
    output bsle_pkg::bsle_ctrl_t          ctrl
);
    import bsle_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    bsle_cmd_t cmd;
    logic      exec;

    assign cmd     = bsle_cmd_t'(s_cmd);
    assign m_valid = (state_reg == ST_FULL);
    assign s_ready = (state_reg == ST_EMPTY) || m_ready;
    assign exec    = s_valid && s_ready;

    always_comb begin
        ctrl.exec      = exec;
        ctrl.op        = OP_NONE;
        ctrl.empty_err = 1'b0;
        ctrl.full_err  = 1'b0;
        if (exec) begin
            unique case (cmd)
                CMD_POP: begin
                    if (stat.cnt_zero) begin
                        ctrl.empty_err = 1'b1;
                    end else begin
                        ctrl.op = OP_POP;
                    end
                end
                CMD_PUSH: begin
                    if (stat.cnt_full) ctrl.full_err = 1'b1;
                    else ctrl.op = OP_PUSH;
                end
                CMD_APPEND: begin
                    if (stat.cnt_full) ctrl.full_err = 1'b1;
                    else ctrl.op = OP_APPEND;
                end
                CMD_INSERT: begin
                    if (stat.cnt_full) ctrl.full_err = 1'b1;
                    else ctrl.op = OP_INSERT;
                end
                default: ctrl.op = OP_NONE;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        if (exec) begin
            state_next = ST_FULL;
        end else if (m_ready) begin
            state_next = ST_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bsle_datapath.sv
module bsle_datapath #(
    parameter int DEPTH = bsle_pkg::DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bsle_pkg::bsle_ctrl_t                  ctrl,
    output bsle_pkg::bsle_stat_t                  stat,
    input  logic signed [bsle_pkg::DATA_W-1:0]    s_value,
    input  logic signed [bsle_pkg::DATA_W-1:0]    s_position,
    output logic signed [bsle_pkg::DATA_W-1:0]    m_popped_value,
    output logic                                  m_empty_error,
    output logic                                  m_full_error,
    output logic [bsle_pkg::OUT_CNT_W-1:0]        m_entry_count
);
    import bsle_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] cell_reg [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         ins_idx;
    logic [CNT_W-1:0]         place_idx;
    logic                     place_en;
    logic                     pos_gt_zero;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic                     empty_reg;
    logic                     full_reg;

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_full = (count_reg == CNT_W'(DEPTH));

    assign pos_gt_zero = !s_position[DATA_W-1] && (s_position != '0);

    always_comb begin
        if (!pos_gt_zero) begin
            ins_idx = '0;
        end else if (32'(unsigned'(s_position)) >= 32'(count_reg)) begin
            ins_idx = count_reg;
        end else begin
            ins_idx = CNT_W'(unsigned'(s_position));
        end
    end

    always_comb begin
        place_en  = 1'b0;
        place_idx = '0;
        unique case (ctrl.op)
            OP_PUSH: begin
                place_en = 1'b1;
            end
            OP_APPEND: begin
                place_en  = 1'b1;
                place_idx = count_reg;
            end
            OP_INSERT: begin
                place_en  = 1'b1;
                place_idx = ins_idx;
            end
            default: place_en = 1'b0;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] I_C = CNT_W'(i);
        logic signed [DATA_W-1:0] from_prev;
        logic signed [DATA_W-1:0] from_next;
        logic signed [DATA_W-1:0] cell_next;

        if (i == 0) begin : g_first
            assign from_prev = cell_reg[i];
        end else begin : g_prev
            assign from_prev = cell_reg[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign from_next = cell_reg[i];
        end else begin : g_next
            assign from_next = cell_reg[i+1];
        end

        always_comb begin
            cell_next = cell_reg[i];
            if (ctrl.op == OP_POP) begin
                cell_next = from_next;
            end else if (place_en) begin
                if (I_C == place_idx) begin
                    cell_next = s_value;
                end else if (I_C > place_idx) begin
                    cell_next = from_prev;
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[i] <= cell_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.op == OP_POP) begin
            count_next = count_reg - CNT_W'(1);
        end else if (place_en) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        if (ctrl.op == OP_POP) begin
            popped_next = cell_reg[0];
        end else if (ctrl.empty_err) begin
            popped_next = POP_EMPTY_VALUE;
        end else begin
            popped_next = POP_NONE_VALUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            popped_reg <= popped_next;
            empty_reg  <= ctrl.empty_err;
            full_reg   <= ctrl.full_err;
        end
    end

    assign m_popped_value = popped_reg;
    assign m_empty_error  = empty_reg;
    assign m_full_error   = full_reg;
    assign m_entry_count  = OUT_CNT_W'(count_reg);

endmodule

FILE: rtl/bounded_sequence_list_engine.sv
// Bounded double-ended list of signed 16-bit values with positional insert.
// Input channel (s_*): one command per transfer; s_cmd selects push front,
// pop front, append back or insert at s_position (zero or less means front,
// at or past the count means back). Output channel (m_*): one result per
// command with the popped value, empty and full error flags, and the entry
// count after the command.
// The result is valid in the cycle after the input transfer.
// Throughput: one command per cycle while m_ready is high. Every cell
// of the shifting store takes its left neighbor, right neighbor, the new
// value or its own value, so a positional insert costs the same as a push.
// The output register accepts a new command in the same cycle its held
// result is taken; while m_ready stays low with a result held, s_ready is
// low and the store and count hold.
// Reset (aresetn low, synchronous) empties the list and drops any held
// result; stored values are left as they are and are never read before
// being written.
module bounded_sequence_list_engine #(
    parameter int DEPTH = bsle_pkg::DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bsle_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [bsle_pkg::DATA_W-1:0]    s_value,
    input  logic signed [bsle_pkg::DATA_W-1:0]    s_position,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bsle_pkg::DATA_W-1:0]    m_popped_value,
    output logic                                  m_empty_error,
    output logic                                  m_full_error,
    output logic [bsle_pkg::OUT_CNT_W-1:0]        m_entry_count
);
    import bsle_pkg::*;

    bsle_ctrl_t ctrl;
    bsle_stat_t stat;

    bsle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    bsle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_popped_value (m_popped_value),
        .m_empty_error  (m_empty_error),
        .m_full_error   (m_full_error),
        .m_entry_count  (m_entry_count)
    );

endmodule

FILE: rtl/bsle_checker.sv
`include "bounded_sequence_list_engine_defines.svh"

module bsle_checker #(
    parameter int DEPTH = bsle_pkg::DEPTH_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [bsle_pkg::DATA_W-1:0]    m_popped_value,
    input logic                                  m_empty_error,
    input logic                                  m_full_error,
    input logic [bsle_pkg::OUT_CNT_W-1:0]        m_entry_count
);
    import bsle_pkg::*;

    logic                          m_stall;
    logic [DATA_W+OUT_CNT_W+1:0]   m_payload;
    logic                          empty_pop_ok;
    logic                          full_add_ok;

    assign m_stall      = m_valid && !m_ready;
    assign m_payload    = {m_popped_value, m_empty_error, m_full_error, m_entry_count};
    assign empty_pop_ok = !m_full_error && (m_popped_value == POP_EMPTY_VALUE)
                          && (m_entry_count == '0);
    assign full_add_ok  = (m_popped_value == POP_NONE_VALUE)
                          && (m_entry_count == OUT_CNT_W'(DEPTH));

    `BSLE_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_valid && s_ready, m_valid)
    `BSLE_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_stall, m_valid && $stable(m_payload))
    `BSLE_ASSERT_NOW(a_empty_pop, aclk, aresetn, m_valid && m_empty_error, empty_pop_ok)
    `BSLE_ASSERT_NOW(a_full_add, aclk, aresetn, m_valid && m_full_error, full_add_ok)

endmodule

bind bounded_sequence_list_engine bsle_checker #(.DEPTH(DEPTH)) u_bsle_checker (.*);
